// ===== design/fsqrt_pkg.sv =====
// Shared types and constants for the single-precision square root core.
// No dependencies.
package fsqrt_pkg;

  localparam int unsigned RootBits  = 25;  // 24 significand bits plus round bit
  localparam int unsigned RadBits   = 50;  // scaled significand width
  localparam int unsigned RemBits   = 27;  // partial remainder width
  localparam int unsigned CellCount = RootBits;
  localparam int unsigned CntBits   = 5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  // Data that moves from one recurrence cell to the next.
  typedef struct packed {
    logic [RadBits-1:0] rad;
    logic [RemBits-1:0] rem;
    logic [RootBits-1:0] root;
  } cell_data_t;

endpackage

// ===== design/float_square_root_core.sv =====
// Top level of the single-precision square root core.
// Depends on fsqrt_pkg and fsqrt_chain.
//
// Usage: an item on the in_ channel carries one binary32 operand in
// in_tdata. The result item on the out_ channel carries the rounded root in
// out_tdata and the domain error flag in out_tuser.
// The block works on one item at a time. After acceptance it unpacks and
// normalizes the operand and loads it into a chain of 25 recurrence cells
// (one root bit per cell), walks the item once around that chain, and then
// rounds the result into the output register. in_tready is high only while
// the core is idle, so no new item is accepted until the last result has
// been taken.
// Special operands (NaN, infinity, zero, negative) still take the same path.
// The result sits in an output register until taken; while the receiver
// stalls, no new item is accepted. Synchronous active-low reset returns the
// core to idle with no result pending.
module float_square_root_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] operand_bits
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] root_bits
  output logic        out_tuser   // [0] domain_error
);

  fsqrt_pkg::state_t state_r, state_nxt;
  logic [fsqrt_pkg::CntBits-1:0] cnt_r, cnt_nxt;
  logic load, step, prep_r, prep_nxt, fin;

  // Operand captured at acceptance.
  logic [31:0] x_r;
  // Classification and exponent held for the rounding step.
  logic        spec_r, err_r;
  logic [31:0] spec_val_r;
  logic signed [9:0] rexp_r;
  logic [31:0] root_r, root_nxt;
  logic        derr_r, derr_nxt;

  // Normalization of the captured operand.
  logic [7:0]  bexp;
  logic [22:0] mant;
  logic [23:0] m;
  logic [4:0]  lz;
  logic signed [9:0] e;
  logic [5:0]  shamt;
  fsqrt_pkg::cell_data_t load_data, result;

  always_comb begin
    bexp = x_r[30:23];
    mant = x_r[22:0];
    lz = 5'd0;
    for (int i = 22; i >= 0; i--) begin
      if (mant[i] && lz == 5'd0 && (mant >> (i + 1)) == 23'd0) begin
        lz = 5'(22 - i);
      end
    end
    if (bexp == 8'd0) begin
      m = 24'(mant) << (lz + 5'd1);
      e = -10'sd149 - 10'(lz) - 10'sd1;
    end else begin
      m = {1'b1, mant};
      e = 10'(bexp) - 10'sd150;
    end
    shamt = e[0] ? 6'd25 : 6'd26;
    load_data.rad  = fsqrt_pkg::RadBits'(m) << shamt;
    load_data.rem  = '0;
    load_data.root = '0;
  end

  fsqrt_chain u_chain (
    .clk       (clk),
    .load      (load),
    .step      (step),
    .load_data (load_data),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fsqrt_pkg::ST_IDLE;
      cnt_r   <= '0;
      prep_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      prep_r  <= prep_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    prep_nxt  = 1'b0;
    load      = 1'b0;
    step      = 1'b0;
    fin       = 1'b0;
    in_tready = 1'b0;
    out_tvalid = 1'b0;
    case (state_r)
      fsqrt_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          prep_nxt  = 1'b1;
          state_nxt = fsqrt_pkg::ST_RUN;
          cnt_nxt   = '0;
        end
      end
      fsqrt_pkg::ST_RUN: begin
        if (prep_r) begin
          load = 1'b1;
        end else if (cnt_r == fsqrt_pkg::CntBits'(fsqrt_pkg::CellCount)) begin
          fin = 1'b1;
          state_nxt = fsqrt_pkg::ST_DONE;
        end else begin
          step = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      fsqrt_pkg::ST_DONE: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          state_nxt = fsqrt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = fsqrt_pkg::ST_IDLE;
    endcase
  end

  // Capture the operand and, on the load cycle, its class and exponent.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      x_r <= in_tdata;
    end
    if (load) begin
      if (bexp == 8'hFF && mant != 23'd0) begin
        spec_r     <= 1'b1;
        err_r      <= 1'b0;
        spec_val_r <= x_r | 32'h0040_0000;
      end else if ((bexp == 8'd0 && mant == 23'd0) || x_r[31]) begin
        spec_r     <= 1'b1;
        err_r      <= 1'b1;
        spec_val_r <= '0;
      end else if (bexp == 8'hFF) begin
        spec_r     <= 1'b1;
        err_r      <= 1'b0;
        spec_val_r <= 32'h7F80_0000;
      end else begin
        spec_r     <= 1'b0;
        err_r      <= 1'b0;
        spec_val_r <= '0;
      end
      rexp_r <= 10'sd151 + ((e - $signed(10'(shamt))) >>> 1);
    end
    root_r <= root_nxt;
    derr_r <= derr_nxt;
  end

  // Round to nearest even using the round bit and the remainder as sticky.
  logic [24:0] sig;
  logic [9:0]  rexp;
  always_comb begin
    root_nxt = root_r;
    derr_nxt = derr_r;
    sig  = {1'b0, result.root[24:1]};
    rexp = rexp_r;
    if (result.root[0] && (result.rem != '0 || result.root[1])) begin
      sig = sig + 25'd1;
      if (sig[24]) begin
        sig  = sig >> 1;
        rexp = rexp + 10'd1;
      end
    end
    if (fin) begin
      derr_nxt = err_r;
      root_nxt = spec_r ? spec_val_r : {rexp[8:0], sig[22:0]};
    end
  end

  assign out_tdata = root_r;
  assign out_tuser = derr_r;

`ifndef ASSERT_OFF
  a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid)
    else $error("input ready while a result is pending");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == 32'd0))
    else $error("domain error with nonzero root");
  a_accept_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == fsqrt_pkg::ST_RUN && prep_r))
    else $error("accepted item did not start");
`endif

endmodule

// ===== design/fsqrt_cell.sv =====
// One digit-recurrence step of the integer square root.
// Depends on fsqrt_pkg.
module fsqrt_cell (
  input  logic                   clk,
  input  logic                   load,
  input  logic                   step,
  input  fsqrt_pkg::cell_data_t  load_data,
  input  fsqrt_pkg::cell_data_t  prev_data,
  output fsqrt_pkg::cell_data_t  data
);

  fsqrt_pkg::cell_data_t data_r;
  fsqrt_pkg::cell_data_t data_nxt;
  logic [fsqrt_pkg::RemBits-1:0] trial;
  logic [fsqrt_pkg::RemBits:0]   diff;

  // Bring down two radicand bits and try root*4+1.
  always_comb begin
    trial = {prev_data.rem[fsqrt_pkg::RemBits-3:0],
             prev_data.rad[fsqrt_pkg::RadBits-1 -: 2]};
    diff  = {1'b0, trial} - {1'b0, prev_data.root, 2'b01};
    data_nxt.rad = {prev_data.rad[fsqrt_pkg::RadBits-3:0], 2'b00};
    if (!diff[fsqrt_pkg::RemBits]) begin
      data_nxt.rem  = diff[fsqrt_pkg::RemBits-1:0];
      data_nxt.root = {prev_data.root[fsqrt_pkg::RootBits-2:0], 1'b1};
    end else begin
      data_nxt.rem  = trial;
      data_nxt.root = {prev_data.root[fsqrt_pkg::RootBits-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end else if (step) begin
      data_r <= data_nxt;
    end
  end

  assign data = data_r;

endmodule

// ===== design/fsqrt_chain.sv =====
// Ring of recurrence cells; the item circulates one cell per cycle while step is high.
// Depends on fsqrt_pkg and fsqrt_cell.
module fsqrt_chain (
  input  logic                   clk,
  input  logic                   load,
  input  logic                   step,
  input  fsqrt_pkg::cell_data_t  load_data,
  output fsqrt_pkg::cell_data_t  result
);

  fsqrt_pkg::cell_data_t links [fsqrt_pkg::CellCount];

  // Cell 0 is loaded; each cell hands its value forward on every step, so after
  // CellCount steps the item has gone once around the ring and sits in cell 0
  // again with every recurrence step applied.
  for (genvar i = 0; i < fsqrt_pkg::CellCount; i++) begin : g_cell
    fsqrt_cell u_cell (
      .clk       (clk),
      .load      (load && (i == 0)),
      .step      (step),
      .load_data (load_data),
      .prev_data ((i == 0) ? links[fsqrt_pkg::CellCount-1] : links[(i == 0) ? 0 : i-1]),
      .data      (links[i])
    );
  end

  assign result = links[0];

endmodule

// ===== verif/float_square_root_core_tb.sv =====
// Testbench for float_square_root_core: directed table, then random binary32 operands.
// Results are checked against typed-in values or a bit-exact square root predictor; depends on the core only.
module float_square_root_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 4000;
  localparam int DirCount = 24;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tuser;

  typedef struct packed {
    logic [31:0] root;
    logic        err;
  } root_item_t;

  root_item_t pending_roots[$];
  int         fail_count = 0;
  int         idle_cycles = 0;
  bit         timed_out = 1'b0;

  // Directed operands; the known flag marks rows whose result is typed in.
  logic [31:0] dir_op[DirCount] = '{
    32'h0000_0000, 32'h8000_0000, 32'hBF80_0000, 32'hFF80_0000, 32'h7F80_0000,
    32'h7FC0_0000, 32'h7F80_0001, 32'hFFBF_FFFF, 32'h8000_0001, 32'h3F80_0000,
    32'h4080_0000, 32'h0000_0001, 32'h007F_FFFF, 32'h0040_0000, 32'h0080_0000,
    32'h7F7F_FFFF, 32'h4000_0000, 32'h3F7F_FFFF, 32'h3F80_0001, 32'h4040_0000,
    32'h0000_0002, 32'h4110_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF};
  root_item_t dir_res[DirCount] = '{
    {32'h0, 1'b1}, {32'h0, 1'b1}, {32'h0, 1'b1}, {32'h0, 1'b1}, {32'h7F80_0000, 1'b0},
    {32'h7FC0_0000, 1'b0}, {32'h7FC0_0001, 1'b0}, {32'hFFFF_FFFF, 1'b0}, {32'h0, 1'b1},
    {32'h3F80_0000, 1'b0}, {32'h4000_0000, 1'b0}, '0, '0, '0, '0, '0, '0, '0, '0, '0,
    '0, {32'h4040_0000, 1'b0}, {32'hFFFF_FFFF, 1'b0}, {32'h7FFF_FFFF, 1'b0}};
  bit dir_known[DirCount] = '{1,1,1,1,1,1,1,1,1,1,1,0,0,0,0,0,0,0,0,0,0,1,1,1};

  float_square_root_core uut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Correctly rounded binary32 square root, ties to even.
  function automatic root_item_t predict_root(logic [31:0] x);
    root_item_t  res;
    logic [7:0]  bexp;
    logic [22:0] mant;
    logic [23:0] m;
    logic [63:0] rad, acc, bit_w, rem, r;
    logic [23:0] sig;
    int          e, shift, rexp;
    bexp = x[30:23];
    mant = x[22:0];
    res = '0;
    if (bexp == 8'hFF && mant != 0) begin
      res.root = x | 32'h0040_0000;
    end else if ((bexp == 0 && mant == 0) || x[31]) begin
      res.err = 1'b1;
    end else if (bexp == 8'hFF) begin
      res.root = 32'h7F80_0000;
    end else begin
      if (bexp == 0) begin
        m = {1'b0, mant};
        e = -149;
        while (!m[23]) begin
          m = m << 1;
          e--;
        end
      end else begin
        m = {1'b1, mant};
        e = int'(bexp) - 150;
      end
      shift = (e % 2 != 0) ? 25 : 26;
      rad = 64'(m) << shift;
      acc = '0;
      bit_w = 64'd1 << 50;
      while (bit_w != 0) begin
        if (rad >= acc + bit_w) begin
          rad = rad - (acc + bit_w);
          acc = (acc >> 1) + bit_w;
        end else begin
          acc = acc >> 1;
        end
        bit_w = bit_w >> 2;
      end
      rem = rad;
      r = acc;
      sig = r[24:1];
      rexp = 151 + (e - shift) / 2;
      if (r[0] && (rem != 0 || sig[0])) begin
        sig = sig + 24'd1;
        if (sig == 0) begin
          sig = 24'h80_0000;
          rexp++;
        end
      end
      res.root = {1'b0, rexp[7:0], sig[22:0]};
    end
    return res;
  endfunction

  // Mostly positive normals, with subnormals, specials and negatives mixed in.
  function automatic logic [31:0] random_operand();
    logic [31:0] v;
    int          pick;
    v = $urandom();
    pick = $urandom_range(0, 19);
    if (pick < 12) v[31] = 1'b0;
    else if (pick < 14) v[30:23] = 8'h00;
    else if (pick == 14) v[30:23] = 8'hFF;
    else if (pick == 15) v[22:0] = '0;
    return v;
  endfunction

  task automatic send_operand(logic [31:0] op, bit known, root_item_t res);
    if ($urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= op;
    do @(posedge clk); while (!in_tready);
    pending_roots.push_back(known ? res : predict_root(op));
  endtask

  // Receiver stalls follow their own cycle pattern, with quiet stretches.
  int stall_phase = 0;
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    if (stall_phase[9]) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(0, 2) != 0);
  end

  // Result checking and watchdog.
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_tvalid && out_tready) begin
        if (pending_roots.size() == 0) begin
          $error("unexpected result item root_bits=%h", out_tdata);
          fail_count = fail_count + 1;
        end else begin
          root_item_t exp_r;
          exp_r = pending_roots.pop_front();
          if (out_tdata !== exp_r.root) begin
            $error("root_bits expected %h actual %h", exp_r.root, out_tdata);
            fail_count = fail_count + 1;
          end
          if (out_tuser !== exp_r.err) begin
            $error("domain_error expected %b actual %b", exp_r.err, out_tuser);
            fail_count = fail_count + 1;
          end
        end
      end
      if (idle_cycles >= WatchdogLimit) timed_out = 1'b1;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < DirCount; i++) send_operand(dir_op[i], dir_known[i], dir_res[i]);
    for (int i = 0; i < 1500; i++) send_operand(random_operand(), 1'b0, '0);
    in_tvalid <= 1'b0;
    while (pending_roots.size() != 0 && !timed_out) @(posedge clk);
    repeat (40) @(posedge clk);
    if (timed_out) begin
      $display("float_square_root_core_tb: done, errors");
    end else if (fail_count == 0 && pending_roots.size() == 0) begin
      $display("float_square_root_core_tb: done, clean");
    end else begin
      $display("float_square_root_core_tb: done, errors");
    end
    $finish;
  end

  // The stimulus loop may hang on a dead handshake; end the run from here.
  initial begin
    wait (timed_out);
    $display("float_square_root_core_tb: done, errors");
    $finish;
  end
endmodule
